// ===== rtl/bti_pkg.sv =====
// Package for the bilinear table interpolation unit.
// Holds shared constants, opcode and register index codes, and helper functions.
// No dependencies.
`default_nettype none

package bti_pkg;

    localparam int DEF_TABLE_DEPTH   = 256;
    localparam int DEF_FRACTION_BITS = 8;
    localparam int DEF_VALUE_BITS    = 16;

    localparam int ADDR_FIELD_BITS  = 8;
    localparam int POS_BITS         = 12;
    localparam int LAST_BITS        = 4;
    // Corner addresses of a 16 by 16 table never exceed 255.
    localparam int CORNER_ADDR_BITS = 8;
    localparam int WRAP_BITS        = 13;
    localparam int CFG_INDEX_BITS   = 1;
    localparam int CFG_DATA_BITS    = 4;

    localparam logic [LAST_BITS-1:0] LAST_RESET = 4'd15;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_LOOKUP = 1'b1
    } opcode_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_X_LAST = 1'b0,
        CFG_Y_LAST = 1'b1
    } cfg_index_t;

    typedef enum logic {
        BK_IDLE,
        BK_READ
    } bk_state_t;

    typedef enum logic [1:0] {
        C00 = 2'd0,
        C01 = 2'd1,
        C10 = 2'd2,
        C11 = 2'd3
    } corner_t;

    // Width of one queue entry between the front and the back.
    function automatic int qentry_bits(input int addr_bits, input int value_bits,
                                       input int fraction_bits);
        return 2 + 5 * addr_bits + value_bits + 4 * (fraction_bits + 1);
    endfunction

    // Reduces a corner address modulo the table depth by restoring subtraction,
    // one step per address bit.
    function automatic logic [WRAP_BITS-1:0] wrap_addr(
        input logic [CORNER_ADDR_BITS-1:0] a,
        input int depth
    );
        logic [WRAP_BITS-1:0] r;
        r = WRAP_BITS'(a);
        for (int k = CORNER_ADDR_BITS - 1; k >= 0; k--) begin
            if (int'(r) >= (depth << k)) begin
                r = r - WRAP_BITS'(depth << k);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bti_fifo.sv =====
// Small register FIFO with valid/ready on both sides and a fill count.
// Used as the command queue and as the result buffer. No dependencies.
`default_nettype none

module bti_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int PTR_BITS   = $clog2(DEPTH),
    localparam int COUNT_BITS = $clog2(DEPTH + 1)
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push_valid,
    output logic                       push_ready,
    input  wire logic [WIDTH-1:0]      push_data,
    output logic                       pop_valid,
    input  wire logic                  pop_ready,
    output logic [WIDTH-1:0]           pop_data,
    output logic [COUNT_BITS-1:0]      count
);

    logic [WIDTH-1:0]      slot_reg [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  push;
    logic                  pop;

    assign push_ready = (count_reg != COUNT_BITS'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign count      = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                                                               : wr_ptr_reg + PTR_BITS'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                                                               : rd_ptr_reg + PTR_BITS'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + COUNT_BITS'(1);
        end else if (pop && !push) begin
            count_next = count_reg - COUNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bti_front.sv =====
// Front end: holds the last-index registers, accepts items and turns each one
// into a queue entry (write command, or four corner addresses and weights).
// Depends on bti_pkg.
`default_nettype none

module bti_front #(
    parameter int TABLE_DEPTH   = 256,
    parameter int FRACTION_BITS = 8,
    parameter int VALUE_BITS    = 16,
    localparam int ADDR_BITS    = $clog2(TABLE_DEPTH),
    localparam int ENTRY_BITS   = bti_pkg::qentry_bits(ADDR_BITS, VALUE_BITS, FRACTION_BITS)
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [bti_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [bti_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic                                  opcode,
    input  wire logic [bti_pkg::ADDR_FIELD_BITS-1:0]   entry_address,
    input  wire logic signed [VALUE_BITS-1:0]          entry_value,
    input  wire logic [bti_pkg::POS_BITS-1:0]          x_pos,
    input  wire logic [bti_pkg::POS_BITS-1:0]          y_pos,
    output logic                                       q_valid,
    input  wire logic                                  q_ready,
    output logic [ENTRY_BITS-1:0]                      q_data
);

    import bti_pkg::*;

    localparam int WB = FRACTION_BITS + 1;
    localparam logic [WB-1:0] W_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

    typedef struct packed {
        logic                          is_lookup;
        logic                          wr_ok;
        logic [ADDR_BITS-1:0]          wr_addr;
        logic signed [VALUE_BITS-1:0]  wr_value;
        logic [ADDR_BITS-1:0]          a00;
        logic [ADDR_BITS-1:0]          a01;
        logic [ADDR_BITS-1:0]          a10;
        logic [ADDR_BITS-1:0]          a11;
        logic [WB-1:0]                 wx0;
        logic [WB-1:0]                 wx1;
        logic [WB-1:0]                 wy0;
        logic [WB-1:0]                 wy1;
    } qentry_t;

    logic [LAST_BITS-1:0]        x_last_reg;
    logic [LAST_BITS-1:0]        y_last_reg;
    logic [LAST_BITS-1:0]        xl, yl;
    logic [POS_BITS-1:0]         x_whole, y_whole;
    logic                        x_clamp, y_clamp;
    logic [LAST_BITS-1:0]        xi, yi;
    logic [LAST_BITS:0]          stride;
    logic [2*LAST_BITS:0]        xs;
    logic [CORNER_ADDR_BITS-1:0] r0, r1;
    logic [WRAP_BITS-1:0]        w00, w01, w10, w11;
    logic [WRAP_BITS-1:0]        wr_ext;
    qentry_t                     entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            x_last_reg <= LAST_RESET;
            y_last_reg <= LAST_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_X_LAST: x_last_reg <= cfg_data;
                CFG_Y_LAST: y_last_reg <= cfg_data;
            endcase
        end
    end

    // A last index of zero behaves as one.
    assign xl = (x_last_reg == '0) ? LAST_BITS'(1) : x_last_reg;
    assign yl = (y_last_reg == '0) ? LAST_BITS'(1) : y_last_reg;

    assign x_whole = x_pos >> FRACTION_BITS;
    assign y_whole = y_pos >> FRACTION_BITS;
    assign x_clamp = (x_whole >= {{(POS_BITS-LAST_BITS){1'b0}}, xl});
    assign y_clamp = (y_whole >= {{(POS_BITS-LAST_BITS){1'b0}}, yl});
    assign xi      = x_clamp ? xl - LAST_BITS'(1) : x_whole[LAST_BITS-1:0];
    assign yi      = y_clamp ? yl - LAST_BITS'(1) : y_whole[LAST_BITS-1:0];

    assign stride = {1'b0, yl} + (LAST_BITS+1)'(1);
    assign xs     = {{(LAST_BITS+1){1'b0}}, xi} * {{LAST_BITS{1'b0}}, stride};
    assign r0     = xs[CORNER_ADDR_BITS-1:0] + CORNER_ADDR_BITS'(yi);
    assign r1     = r0 + CORNER_ADDR_BITS'(stride);

    assign w00    = wrap_addr(r0, TABLE_DEPTH);
    assign w01    = wrap_addr(r0 + CORNER_ADDR_BITS'(1), TABLE_DEPTH);
    assign w10    = wrap_addr(r1, TABLE_DEPTH);
    assign w11    = wrap_addr(r1 + CORNER_ADDR_BITS'(1), TABLE_DEPTH);
    assign wr_ext = WRAP_BITS'(entry_address);

    always_comb
    begin
        entry.is_lookup = (opcode == OP_LOOKUP);
        // Writes beyond the table are dropped.
        entry.wr_ok     = (wr_ext < WRAP_BITS'(TABLE_DEPTH));
        entry.wr_addr   = wr_ext[ADDR_BITS-1:0];
        entry.wr_value  = entry_value;
        entry.a00       = w00[ADDR_BITS-1:0];
        entry.a01       = w01[ADDR_BITS-1:0];
        entry.a10       = w10[ADDR_BITS-1:0];
        entry.a11       = w11[ADDR_BITS-1:0];
        entry.wx1       = x_clamp ? W_ONE : {1'b0, x_pos[FRACTION_BITS-1:0]};
        entry.wy1       = y_clamp ? W_ONE : {1'b0, y_pos[FRACTION_BITS-1:0]};
        entry.wx0       = W_ONE - entry.wx1;
        entry.wy0       = W_ONE - entry.wy1;
    end

    assign q_valid  = in_valid;
    assign in_ready = q_ready;
    assign q_data   = entry;

endmodule

`default_nettype wire

// ===== rtl/bti_back.sv =====
// Back end: owns the single-port table, applies writes, reads four corners per
// lookup, blends them in a multiply-accumulate pipeline and buffers results.
// Depends on bti_pkg and bti_fifo.
`default_nettype none

module bti_back #(
    parameter int TABLE_DEPTH   = 256,
    parameter int FRACTION_BITS = 8,
    parameter int VALUE_BITS    = 16,
    localparam int ADDR_BITS    = $clog2(TABLE_DEPTH),
    localparam int ENTRY_BITS   = bti_pkg::qentry_bits(ADDR_BITS, VALUE_BITS, FRACTION_BITS)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         q_valid,
    output logic                              q_ready,
    input  wire logic [ENTRY_BITS-1:0]        q_data,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [VALUE_BITS-1:0]      interpolated
);

    import bti_pkg::*;

    localparam int WB         = FRACTION_BITS + 1;
    localparam int PROD_BITS  = VALUE_BITS + 2 * WB + 1;
    localparam int ACC_BITS   = VALUE_BITS + 2 * FRACTION_BITS + 2;
    localparam int OUT_DEPTH  = 2;
    localparam int OCNT_BITS  = $clog2(OUT_DEPTH + 1);
    localparam int CRED_BITS  = OCNT_BITS + 1;

    typedef struct packed {
        logic                          is_lookup;
        logic                          wr_ok;
        logic [ADDR_BITS-1:0]          wr_addr;
        logic signed [VALUE_BITS-1:0]  wr_value;
        logic [ADDR_BITS-1:0]          a00;
        logic [ADDR_BITS-1:0]          a01;
        logic [ADDR_BITS-1:0]          a10;
        logic [ADDR_BITS-1:0]          a11;
        logic [WB-1:0]                 wx0;
        logic [WB-1:0]                 wx1;
        logic [WB-1:0]                 wy0;
        logic [WB-1:0]                 wy1;
    } qentry_t;

    qentry_t                      head, src, cur_reg;
    bk_state_t                    state_reg, state_next;
    corner_t                      corner_reg, corner_next, issue_corner;
    logic [OCNT_BITS-1:0]         inflight_reg, inflight_next;
    logic [OCNT_BITS-1:0]         out_count;
    logic                         credit_ok;
    logic                         start;
    logic                         mem_we, mem_re;
    logic [ADDR_BITS-1:0]         rd_addr, mem_addr;
    logic [WB-1:0]                wa, wb;

    logic signed [VALUE_BITS-1:0] table_mem [TABLE_DEPTH];
    logic signed [VALUE_BITS-1:0] rdata_reg;
    logic                         s1_valid_reg, s1_first_reg, s1_last_reg;
    logic [2*WB-1:0]              w_reg;
    logic signed [PROD_BITS-1:0]  prod_full;
    logic signed [ACC_BITS-1:0]   prod_reg;
    logic                         s2_valid_reg, s2_first_reg, s2_last_reg;
    logic signed [ACC_BITS-1:0]   acc_reg, sum_now;
    logic                         res_push, res_push_ready;
    logic [VALUE_BITS-1:0]        res_data;
    logic [VALUE_BITS-1:0]        out_data;

    assign head = qentry_t'(q_data);
    assign src  = (state_reg == BK_IDLE) ? head : cur_reg;

    // A lookup starts only if its result is sure to find room in the buffer.
    assign credit_ok = (CRED_BITS'(out_count) + CRED_BITS'(inflight_reg)) < CRED_BITS'(OUT_DEPTH);

    always_comb
    begin
        state_next   = state_reg;
        corner_next  = corner_reg;
        issue_corner = corner_reg;
        q_ready      = 1'b0;
        start        = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
                issue_corner = C00;
                if (q_valid) begin
                    if (head.is_lookup) begin
                        if (credit_ok) begin
                            q_ready     = 1'b1;
                            start       = 1'b1;
                            mem_re      = 1'b1;
                            state_next  = BK_READ;
                            corner_next = C01;
                        end
                    end else begin
                        q_ready = 1'b1;
                        mem_we  = head.wr_ok;
                    end
                end
            end
            BK_READ: begin
                mem_re = 1'b1;
                unique case (corner_reg)
                    C00: corner_next = C01;
                    C01: corner_next = C10;
                    C10: corner_next = C11;
                    C11: begin
                        corner_next = C00;
                        state_next  = BK_IDLE;
                    end
                endcase
            end
        endcase
    end

    always_comb
    begin
        unique case (issue_corner)
            C00: begin rd_addr = src.a00; wa = src.wx0; wb = src.wy0; end
            C01: begin rd_addr = src.a01; wa = src.wx0; wb = src.wy1; end
            C10: begin rd_addr = src.a10; wa = src.wx1; wb = src.wy0; end
            C11: begin rd_addr = src.a11; wa = src.wx1; wb = src.wy1; end
        endcase
    end

    assign mem_addr = mem_we ? head.wr_addr : rd_addr;

    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            table_mem[mem_addr] <= head.wr_value;
        end
        if (mem_re) begin
            rdata_reg <= table_mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg    <= BK_IDLE;
            corner_reg   <= C00;
            inflight_reg <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            corner_reg   <= corner_next;
            inflight_reg <= inflight_next;
            s1_valid_reg <= mem_re;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_comb
    begin
        inflight_next = inflight_reg;
        if (start && !res_push) begin
            inflight_next = inflight_reg + OCNT_BITS'(1);
        end else if (res_push && !start) begin
            inflight_next = inflight_reg - OCNT_BITS'(1);
        end
    end

    assign prod_full = rdata_reg * $signed({1'b0, w_reg});
    assign sum_now   = (s2_first_reg ? ACC_BITS'(0) : acc_reg) + prod_reg;
    assign res_push  = s2_valid_reg && s2_last_reg;
    // Floor shift: drop the fraction bits of the weighted sum.
    assign res_data  = sum_now[2*FRACTION_BITS+VALUE_BITS-1:2*FRACTION_BITS];

    always_ff @(posedge clk)
    begin
        if (start) begin
            cur_reg <= head;
        end
        s1_first_reg <= (issue_corner == C00);
        s1_last_reg  <= (issue_corner == C11);
        w_reg        <= wa * wb;
        prod_reg     <= prod_full[ACC_BITS-1:0];
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        if (s2_valid_reg) begin
            acc_reg <= sum_now;
        end
    end

    bti_fifo #(
        .WIDTH (VALUE_BITS),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (res_push),
        .push_ready (res_push_ready),
        .push_data  (res_data),
        .pop_valid  (out_valid),
        .pop_ready  (out_ready),
        .pop_data   (out_data),
        .count      (out_count)
    );

    assign interpolated = out_data;

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (CRED_BITS'(out_count) + CRED_BITS'(inflight_reg)) <= CRED_BITS'(OUT_DEPTH))
        else $error("result buffer credits exceeded");

    a_push_has_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (inflight_reg != '0))
        else $error("result produced with no lookup in flight");

    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> res_push_ready)
        else $error("result buffer overflow");

    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_READ && corner_reg == C11) |=> (s1_valid_reg && s1_last_reg))
        else $error("last corner read not tagged");

    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("table port used for read and write at once");

endmodule

`default_nettype wire

// ===== rtl/bilinear_table_interpolation_unit.sv =====
// Bilinear table interpolation unit, top level. Depends on bti_pkg, bti_fifo,
// bti_front and bti_back.
// A lookup blends four corner reads issued in turn through the single table port,
// and the back end takes no new queue entry until all four are issued; a lookup
// also waits for room in the result buffer. Writes give no result.
// Reset clears all control state and sets both last indices to 15; table
// contents are undefined until written and are not cleared.
`default_nettype none

module bilinear_table_interpolation_unit #(
    parameter int TABLE_DEPTH   = bti_pkg::DEF_TABLE_DEPTH,
    parameter int FRACTION_BITS = bti_pkg::DEF_FRACTION_BITS,
    parameter int VALUE_BITS    = bti_pkg::DEF_VALUE_BITS
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [bti_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [bti_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic                                  opcode,
    input  wire logic [bti_pkg::ADDR_FIELD_BITS-1:0]   entry_address,
    input  wire logic signed [VALUE_BITS-1:0]          entry_value,
    input  wire logic [bti_pkg::POS_BITS-1:0]          x_pos,
    input  wire logic [bti_pkg::POS_BITS-1:0]          y_pos,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed [VALUE_BITS-1:0]               interpolated
);

    import bti_pkg::*;

    localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
    localparam int ENTRY_BITS  = qentry_bits(ADDR_BITS, VALUE_BITS, FRACTION_BITS);
    localparam int QUEUE_DEPTH = 2;

    logic                  fq_valid, fq_ready;
    logic [ENTRY_BITS-1:0] fq_data;
    logic                  bq_valid, bq_ready;
    logic [ENTRY_BITS-1:0] bq_data;

    bti_front #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .FRACTION_BITS (FRACTION_BITS),
        .VALUE_BITS    (VALUE_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .entry_address (entry_address),
        .entry_value   (entry_value),
        .x_pos         (x_pos),
        .y_pos         (y_pos),
        .q_valid       (fq_valid),
        .q_ready       (fq_ready),
        .q_data        (fq_data)
    );

    bti_fifo #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (bq_valid),
        .pop_ready  (bq_ready),
        .pop_data   (bq_data),
        .count      ()
    );

    bti_back #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .FRACTION_BITS (FRACTION_BITS),
        .VALUE_BITS    (VALUE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (bq_valid),
        .q_ready      (bq_ready),
        .q_data       (bq_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .interpolated (interpolated)
    );

endmodule

`default_nettype wire
